// ----- sv/sdls_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdls_pkg: shared types and constants for the sorted dual list store
// Operation and status codes, pool sizing and the sequencer state type.
// ----------------------------------------------------------------------------
package sdls_pkg;

   localparam int POOL_ENTRIES = 32;
   localparam int IDX_W        = $clog2(POOL_ENTRIES);
   localparam int CNT_W        = $clog2(POOL_ENTRIES + 1);
   localparam int LEN_W        = 6;

   typedef enum logic [1:0] {
      KIND_INSERT = 2'd0,
      KIND_DELETE = 2'd1,
      KIND_MERGE  = 2'd2,
      KIND_DUMP   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_EMPTY     = 2'd2,
      ST_NO_MEMORY = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECIDE,
      S_SEARCH,
      S_SHIFT,
      S_DUMP,
      S_MERGE,
      S_COPY,
      S_RESP
   } state_type;

   // signed compare as unsigned on flipped sign bit
   function automatic logic key_gt(input logic [7:0] a, input logic [7:0] b);
      key_gt = ({~a[7], a[6:0]} > {~b[7], b[6:0]});
   endfunction

endpackage

// ----- sv/sorted_dual_list_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_dual_list_store: two sorted signed-byte lists sharing one pool
// Insert, delete, merge and dump over two ascending multisets.
// ----------------------------------------------------------------------------
// Insert and delete search, then shift one entry a cycle.
// Throughput: one request at a time.
// Reset: synchronous, active high; clears both list counts and the
//   sequencer. Memory contents are not cleared.
module sorted_dual_list_store
   import sdls_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [1:0]       req_kind,
   input  logic             req_list_sel,
   input  logic signed [7:0] req_value,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [1:0]       rsp_status,
   output logic signed [7:0] rsp_item_value,
   output logic [5:0]       rsp_list_length,
   output logic             rsp_last
);

   // list memories and a merge scratch memory
   logic [7:0] mem_a [POOL_ENTRIES];
   logic [7:0] mem_b [POOL_ENTRIES];
   logic [7:0] mem_t [POOL_ENTRIES];

   state_type state_ff, state_in;
   logic [1:0]       kind_ff;
   logic             sel_ff;
   logic [7:0]       val_ff;
   logic [CNT_W-1:0] cnt_a_ff, cnt_a_in, cnt_b_ff, cnt_b_in;
   logic [CNT_W-1:0] i_ff, i_in, j_ff, j_in, n_ff, n_in;
   logic [7:0]       hold_ff, hold_in;   // carried entry for insert shift
   logic             phase_ff, phase_in; // read / use phase
   logic [1:0]       st_ff, st_in;
   logic [7:0]       item_ff, item_in;
   logic             last_ff, last_in;
   logic [7:0]       rd_a_ff, rd_b_ff, rd_t_ff;

   // read addresses and write controls
   logic [IDX_W-1:0] ra_a, ra_b, ra_t, wa_a, wa_b, wa_t;
   logic             we_a, we_b, we_t;
   logic [7:0]       wd_a, wd_b, wd_t;

   logic [CNT_W-1:0] cnt_sel;
   logic [7:0]       rd_sel;
   assign cnt_sel = sel_ff ? cnt_b_ff : cnt_a_ff;
   assign rd_sel  = sel_ff ? rd_b_ff : rd_a_ff;

   // memories: one write, one registered read each
   always_ff @(posedge clock) begin
      if (we_a) mem_a[wa_a] <= wd_a;
      if (we_b) mem_b[wa_b] <= wd_b;
      if (we_t) mem_t[wa_t] <= wd_t;
      rd_a_ff <= mem_a[ra_a];
      rd_b_ff <= mem_b[ra_b];
      rd_t_ff <= mem_t[ra_t];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_a_ff <= '0;
         cnt_b_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_a_ff <= cnt_a_in;
         cnt_b_ff <= cnt_b_in;
      end
      i_ff <= i_in; j_ff <= j_in; n_ff <= n_in;
      hold_ff <= hold_in; phase_ff <= phase_in;
      st_ff <= st_in; item_ff <= item_in; last_ff <= last_in;
      if (req_valid && req_ready) begin
         kind_ff <= req_kind;
         sel_ff  <= req_list_sel;
         val_ff  <= req_value;
      end
   end

   // sequencer: next state and datapath
   always_comb begin
      state_in = state_ff;
      cnt_a_in = cnt_a_ff; cnt_b_in = cnt_b_ff;
      i_in = i_ff; j_in = j_ff; n_in = n_ff;
      hold_in = hold_ff; phase_in = phase_ff;
      st_in = st_ff; item_in = item_ff; last_in = last_ff;
      ra_a = i_ff[IDX_W-1:0]; ra_b = i_ff[IDX_W-1:0]; ra_t = i_ff[IDX_W-1:0];
      wa_a = i_ff[IDX_W-1:0]; wa_b = i_ff[IDX_W-1:0]; wa_t = n_ff[IDX_W-1:0];
      we_a = 1'b0; we_b = 1'b0; we_t = 1'b0;
      wd_a = hold_ff; wd_b = hold_ff; wd_t = rd_a_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_DECIDE;
               i_in = '0; j_in = '0; n_in = '0; phase_in = 1'b0;
               st_in = ST_OK; item_in = '0; last_in = 1'b1;
            end
         end
         S_DECIDE: begin
            // i addresses entry 0; its read lands next cycle
            case (kind_type'(kind_ff))
               KIND_INSERT: begin
                  if ({1'b0, cnt_a_ff} + {1'b0, cnt_b_ff} >= (CNT_W+1)'(POOL_ENTRIES)) begin
                     st_in = ST_NO_MEMORY; state_in = S_RESP;
                  end else begin
                     state_in = S_SEARCH;
                  end
               end
               KIND_DELETE: begin
                  if (cnt_sel == '0) begin
                     st_in = ST_EMPTY; state_in = S_RESP;
                  end else begin
                     state_in = S_SEARCH;
                  end
               end
               KIND_MERGE: state_in = S_MERGE;
               default: begin
                  if (cnt_sel == '0) begin
                     st_in = ST_EMPTY; state_in = S_RESP;
                  end else begin
                     state_in = S_DUMP;
                  end
               end
            endcase
         end
         S_SEARCH: begin
            // rd_sel is entry i
            if (kind_ff == KIND_INSERT) begin
               if (i_ff == cnt_sel || !key_gt(val_ff, rd_sel)) begin
                  hold_in = val_ff; state_in = S_SHIFT;
               end else begin
                  i_in = i_ff + 1'b1; ra_a = i_in[IDX_W-1:0]; ra_b = i_in[IDX_W-1:0];
               end
            end else begin
               if (i_ff == cnt_sel) begin
                  st_in = ST_NOT_FOUND; state_in = S_RESP;
               end else if (rd_sel == val_ff) begin
                  item_in = val_ff; state_in = S_SHIFT;
                  i_in = i_ff + 1'b1; ra_a = i_in[IDX_W-1:0]; ra_b = i_in[IDX_W-1:0];
               end else begin
                  i_in = i_ff + 1'b1; ra_a = i_in[IDX_W-1:0]; ra_b = i_in[IDX_W-1:0];
               end
            end
         end
         S_SHIFT: begin
            if (kind_ff == KIND_INSERT) begin
               // write carried entry at i, carry old entry i forward
               wd_a = hold_ff; wd_b = hold_ff;
               we_a = !sel_ff; we_b = sel_ff;
               hold_in = rd_sel;
               i_in = i_ff + 1'b1; ra_a = i_in[IDX_W-1:0]; ra_b = i_in[IDX_W-1:0];
               if (i_ff == cnt_sel) begin
                  if (sel_ff) cnt_b_in = cnt_b_ff + 1'b1;
                  else        cnt_a_in = cnt_a_ff + 1'b1;
                  state_in = S_RESP;
               end
            end else begin
               // rd_sel is entry i; move it to i-1
               if (i_ff == cnt_sel) begin
                  if (sel_ff) cnt_b_in = cnt_b_ff - 1'b1;
                  else        cnt_a_in = cnt_a_ff - 1'b1;
                  state_in = S_RESP;
               end else begin
                  wa_a = IDX_W'(i_ff - 1'b1); wa_b = IDX_W'(i_ff - 1'b1);
                  wd_a = rd_sel; wd_b = rd_sel;
                  we_a = !sel_ff; we_b = sel_ff;
                  i_in = i_ff + 1'b1; ra_a = i_in[IDX_W-1:0]; ra_b = i_in[IDX_W-1:0];
               end
            end
         end
         S_DUMP: begin
            // phase 0 waits for the read, phase 1 presents it
            if (!phase_ff) begin
               item_in = rd_sel; last_in = (i_ff + 1'b1 == cnt_sel);
               phase_in = 1'b1;
            end else if (rsp_ready) begin
               phase_in = 1'b0;
               if (last_ff) begin
                  state_in = S_IDLE;
               end else begin
                  i_in = i_ff + 1'b1; ra_a = i_in[IDX_W-1:0]; ra_b = i_in[IDX_W-1:0];
               end
            end
         end
         S_MERGE: begin
            // i walks list one, j walks list two, n fills scratch
            ra_a = i_ff[IDX_W-1:0]; ra_b = j_ff[IDX_W-1:0];
            if (!phase_ff) begin
               phase_in = 1'b1;
            end else begin
               phase_in = 1'b0;
               if (i_ff == cnt_a_ff && j_ff == cnt_b_ff) begin
                  state_in = S_COPY; cnt_a_in = n_ff; cnt_b_in = '0;
                  i_in = '0; ra_t = '0;
               end else begin
                  we_t = 1'b1;
                  n_in = n_ff + 1'b1;
                  if (j_ff == cnt_b_ff ||
                      (i_ff != cnt_a_ff && !key_gt(rd_a_ff, rd_b_ff))) begin
                     wd_t = rd_a_ff; i_in = i_ff + 1'b1;
                  end else begin
                     wd_t = rd_b_ff; j_in = j_ff + 1'b1;
                  end
                  ra_a = i_in[IDX_W-1:0]; ra_b = j_in[IDX_W-1:0];
               end
            end
         end
         S_COPY: begin
            ra_t = i_ff[IDX_W-1:0];
            if (i_ff == cnt_a_ff) begin
               state_in = S_RESP;
            end else if (!phase_ff) begin
               phase_in = 1'b1;
            end else begin
               phase_in = 1'b0;
               we_a = 1'b1; wd_a = rd_t_ff;
               i_in = i_ff + 1'b1; ra_t = i_in[IDX_W-1:0];
            end
         end
         S_RESP: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready = (state_ff == S_IDLE);
      rsp_valid = (state_ff == S_RESP) || (state_ff == S_DUMP && phase_ff);
      rsp_status = st_ff;
      rsp_item_value = item_ff;
      rsp_last = last_ff;
      if (kind_ff == KIND_MERGE || !sel_ff) rsp_list_length = LEN_W'(cnt_a_ff);
      else                                  rsp_list_length = LEN_W'(cnt_b_ff);
   end

`ifndef SYNTH
   a_pool: assert property (@(posedge clock) disable iff (reset)
      {1'b0, cnt_a_ff} + {1'b0, cnt_b_ff} <= (CNT_W+1)'(POOL_ENTRIES))
      else $error("pool overcommitted");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("ready while responding");
   a_cnt_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && !req_valid) |=> $stable(cnt_a_ff) && $stable(cnt_b_ff))
      else $error("count changed while idle");
`endif

endmodule
